// ===== sv/wes2d_pkg.sv =====
// ----------------------------------------------------------------------------
// wes2d_pkg
// Register map, reset values and fixed arithmetic constants of the 2D wave
// equation stencil core.
// ----------------------------------------------------------------------------
package wes2d_pkg;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_STEP_COEF  = 2'd0;
  localparam logic [1:0] REG_FIRST_STEP = 2'd1;
  localparam logic [1:0] REG_GRID_SIZE  = 2'd2;

  // register widths and reset values
  localparam int COEF_BITS = 24;
  localparam int GRID_BITS = 11;
  localparam logic [COEF_BITS-1:0] COEF_RST  = 24'd41943;
  localparam logic [GRID_BITS-1:0] GRID_RST  = 11'd100;
  localparam int                   GRID_MIN  = 3;

  // coefficient is split in two halves for the product
  localparam int COEF_HALF = 12;
  // fraction bits of k*L: Q0.24, one more in first-step mode
  localparam int SHIFT_NORM  = 24;
  localparam int SHIFT_FIRST = 25;

  // position fields on the result channel
  localparam int POS_BITS = 10;

endpackage

// ===== sv/wave_equation_stencil_2d_core.sv =====
// ----------------------------------------------------------------------------
// wave_equation_stencil_2d_core
// One time step of the 2D wave equation, raster-order stream, line stores in
// block memories, five-point laplacian, saturating Q16.16 result.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------------------
//  in_     | in  | tdata: cur_value, prev_value; tuser: frame_start
//  out_    | out | tdata: new_value, out_row, out_col; tuser: saturated; tlast
//  cfg     | in  | APB: step_coefficient @0x0, first_step @0x4, grid_size @0x8
//
//  One cell per clock while the output keeps up. A result passes the stage 1
//  to 4 registers and then the output register; the rate is set by the single
//  write port of each line store and the one-beat output register. A bottom-row
//  cell gives two beats and can hold back the input. Row-zero cells give none.
//  Reset clears the position counters and registers; line stores are not
//  cleared. Output stalls fill the pipeline bubbles first, then drop in_tready.
// ----------------------------------------------------------------------------
module wave_equation_stencil_2d_core #(
  parameter int MAX_GRID   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [VALUE_BITS-1:0] cur_value, [2*VALUE_BITS-1:VALUE_BITS] prev_value
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0]   in_tdata,
  // [0] frame_start
  input  logic [0:0]                          in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [VALUE_BITS-1:0] new_value, then out_row (10), then out_col (10)
  output logic [((VALUE_BITS+20+7)/8)*8-1:0]  out_tdata,
  // [0] saturated
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wes2d_pkg::CFG_AW-1:0]        paddr,
  input  logic [wes2d_pkg::CFG_DW-1:0]        pwdata,
  output logic [wes2d_pkg::CFG_DW-1:0]        prdata,
  output logic                                pready
);

  localparam int VW  = VALUE_BITS;
  localparam int CW  = $clog2(MAX_GRID);
  localparam int NW  = CW + 1;
  localparam int GW  = (NW > wes2d_pkg::GRID_BITS) ? NW : wes2d_pkg::GRID_BITS;
  localparam int LW  = VW + 3;           // laplacian
  localparam int PW  = LW + 13;          // lap times one coefficient half
  localparam int T2W = LW + 14;          // low product plus rounding
  localparam int SW  = LW + 14;          // scaled term
  localparam int FW  = SW + 2;           // full sum before clipping
  localparam int ODW = ((VW + 20 + 7) / 8) * 8;
  localparam int HB  = wes2d_pkg::COEF_HALF;
  localparam int PB  = wes2d_pkg::POS_BITS;

  localparam logic signed [FW-1:0] VMAX_F = $signed(FW'({1'b0, {(VW-1){1'b1}}}));
  localparam logic signed [FW-1:0] VMIN_F = ~VMAX_F;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [wes2d_pkg::COEF_BITS-1:0] coef_r;
  logic                            first_r;
  logic [wes2d_pkg::GRID_BITS-1:0] grid_r;
  logic                            cfg_wr;
  logic [1:0]                      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= wes2d_pkg::COEF_RST;
      first_r <= 1'b0;
      grid_r  <= wes2d_pkg::GRID_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        wes2d_pkg::REG_STEP_COEF:  coef_r  <= pwdata[wes2d_pkg::COEF_BITS-1:0];
        wes2d_pkg::REG_FIRST_STEP: first_r <= pwdata[0];
        wes2d_pkg::REG_GRID_SIZE:  grid_r  <= pwdata[wes2d_pkg::GRID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wes2d_pkg::REG_STEP_COEF:  prdata = wes2d_pkg::CFG_DW'(coef_r);
      wes2d_pkg::REG_FIRST_STEP: prdata = wes2d_pkg::CFG_DW'(first_r);
      wes2d_pkg::REG_GRID_SIZE:  prdata = wes2d_pkg::CFG_DW'(grid_r);
      default:                   prdata = '0;
    endcase
  end

  // clamped grid size
  logic [GW-1:0] grid_ext;
  logic [GW-1:0] grid_clamp;
  logic [NW-1:0] n;

  assign grid_ext   = GW'(grid_r);
  assign grid_clamp = (grid_ext < GW'(wes2d_pkg::GRID_MIN)) ? GW'(wes2d_pkg::GRID_MIN) :
                      (grid_ext > GW'(MAX_GRID))            ? GW'(MAX_GRID) : grid_ext;
  assign n          = NW'(grid_clamp);

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage moves when empty or when the next moves
  // --------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic s1_en, s2_en, s3_en, s4_en, out_en;
  logic out_dbl_r, out_ph_r, out_done;
  logic in_acc;

  assign out_done  = out_vld_r && out_tready && (out_ph_r || !out_dbl_r);
  assign out_en    = !out_vld_r || out_done;
  assign s4_en     = !s4_vld_r || out_en;
  assign s3_en     = !s3_vld_r || s4_en;
  assign s2_en     = !s2_vld_r || s3_en;
  assign s1_en     = !s1_vld_r || s2_en;
  assign in_tready = s1_en;
  assign in_acc    = in_tvalid && s1_en;

  // --------------------------------------------------------------------------
  // stage 0: cell position and memory read issue
  // --------------------------------------------------------------------------
  logic [CW-1:0] row_r, col_r;
  logic [NW-1:0] base_row, base_col, pos_row_w, pos_col_w, nxt_col_w, nxt_row_w;
  logic [CW-1:0] pos_row, pos_col, pos_col_p1;
  logic          frame_start;
  logic signed [VW-1:0] in_cur, in_prev;

  assign frame_start = in_tuser[0];
  assign in_cur      = $signed(in_tdata[VW-1:0]);
  assign in_prev     = $signed(in_tdata[2*VW-1:VW]);

  always_comb begin
    base_row = frame_start ? '0 : NW'(row_r);
    base_col = frame_start ? '0 : NW'(col_r);
    // column past the end after a shrink moves to the next row
    if (base_col >= n) begin
      pos_col_w = '0;
      pos_row_w = base_row + NW'(1);
    end else begin
      pos_col_w = base_col;
      pos_row_w = base_row;
    end
    if (pos_row_w >= n) pos_row_w = '0;
    // position of the following cell
    nxt_col_w = pos_col_w + NW'(1);
    nxt_row_w = pos_row_w;
    if (nxt_col_w >= n) begin
      nxt_col_w = '0;
      nxt_row_w = pos_row_w + NW'(1);
      if (nxt_row_w >= n) nxt_row_w = '0;
    end
  end

  assign pos_row    = CW'(pos_row_w);
  assign pos_col    = CW'(pos_col_w);
  assign pos_col_p1 = (pos_col == CW'(MAX_GRID - 1)) ? '0 : pos_col + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= CW'(nxt_row_w);
      col_r <= CW'(nxt_col_w);
    end
  end

  // --------------------------------------------------------------------------
  // line stores
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] mem_above [MAX_GRID];
  logic signed [VW-1:0] mem_two   [MAX_GRID];
  logic signed [VW-1:0] mem_prev  [MAX_GRID];
  logic signed [VW-1:0] above_rd, right_rd, two_rd, prev_rd;
  logic [CW-1:0]        s1_col_r;
  logic                 two_wr;

  // row above: two reads (this column and the next), written with cur
  always_ff @(posedge clk) begin
    if (in_acc) begin
      above_rd             <= mem_above[pos_col];
      right_rd             <= mem_above[pos_col_p1];
      mem_above[pos_col]   <= in_cur;
    end
  end

  // older values of the row above
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_rd            <= mem_prev[pos_col];
      mem_prev[pos_col]  <= in_prev;
    end
  end

  // row two above: gets the old row-above value once it has been read
  assign two_wr = s1_vld_r && s1_en;

  always_ff @(posedge clk) begin
    if (in_acc) two_rd <= mem_two[pos_col];
    if (two_wr) mem_two[s1_col_r] <= above_rd;
  end

  // --------------------------------------------------------------------------
  // stage 1: laplacian
  // --------------------------------------------------------------------------
  logic                 s1_res_r, s1_int_r, s1_dbl_r, s1_fwd_r;
  logic [CW-1:0]        s1_tr_r;
  logic signed [VW-1:0] s1_cur_r;
  logic signed [VW-1:0] held_left_r;
  logic signed [VW-1:0] s1_two;
  logic signed [LW-1:0] lap_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (s1_en) s1_vld_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= (pos_row != '0);
      s1_dbl_r <= (pos_row_w == n - NW'(1));
      s1_int_r <= (pos_row >= CW'(2)) && (pos_col != '0) && (pos_col_w <= n - NW'(2));
      s1_tr_r  <= pos_row - CW'(1);
      s1_col_r <= pos_col;
      s1_cur_r <= in_cur;
      // previous cell still in stage 1 writes this column in the same edge
      s1_fwd_r <= s1_vld_r && (s1_col_r == pos_col);
    end
  end

  // left neighbour is the previous cell's row-above value
  always_ff @(posedge clk) begin
    if (!rst_n) held_left_r <= '0;
    else if (two_wr) held_left_r <= above_rd;
  end

  assign s1_two  = s1_fwd_r ? held_left_r : two_rd;
  assign lap_nxt = LW'(s1_two) + LW'(s1_cur_r) + LW'(held_left_r) + LW'(right_rd)
                 - (LW'(above_rd) <<< 2);

  // --------------------------------------------------------------------------
  // stage 2: low coefficient half plus rounding
  // --------------------------------------------------------------------------
  logic                 s2_int_r, s2_dbl_r;
  logic [CW-1:0]        s2_tr_r, s2_col_r;
  logic signed [LW-1:0] s2_lap_r;
  logic signed [VW-1:0] s2_above_r, s2_prev_r;
  logic signed [HB:0]   kl_s, kh_s;
  logic signed [PW-1:0] p_lo, p_hi;
  logic signed [T2W-1:0] half_v, t2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (s2_en) s2_vld_r <= s1_vld_r && s1_res_r;
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_int_r   <= s1_int_r;
      s2_dbl_r   <= s1_dbl_r;
      s2_tr_r    <= s1_tr_r;
      s2_col_r   <= s1_col_r;
      s2_lap_r   <= lap_nxt;
      s2_above_r <= above_rd;
      s2_prev_r  <= prev_rd;
    end
  end

  assign kl_s   = $signed({1'b0, coef_r[HB-1:0]});
  assign kh_s   = $signed({1'b0, coef_r[2*HB-1:HB]});
  assign p_lo   = s2_lap_r * kl_s;
  assign half_v = first_r ? (T2W'(1) <<< (wes2d_pkg::SHIFT_FIRST - 1))
                          : (T2W'(1) <<< (wes2d_pkg::SHIFT_NORM - 1));
  assign t2_nxt = T2W'(p_lo) + half_v;

  // --------------------------------------------------------------------------
  // stage 3: high coefficient half, scale down
  // --------------------------------------------------------------------------
  logic                  s3_int_r, s3_dbl_r;
  logic [CW-1:0]         s3_tr_r, s3_col_r;
  logic signed [LW-1:0]  s3_lap_r;
  logic signed [VW-1:0]  s3_above_r, s3_prev_r;
  logic signed [T2W-1:0] s3_t2_r;
  logic signed [SW-1:0]  sum_v, term_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (s3_en) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_int_r   <= s2_int_r;
      s3_dbl_r   <= s2_dbl_r;
      s3_tr_r    <= s2_tr_r;
      s3_col_r   <= s2_col_r;
      s3_lap_r   <= s2_lap_r;
      s3_above_r <= s2_above_r;
      s3_prev_r  <= s2_prev_r;
      s3_t2_r    <= t2_nxt;
    end
  end

  assign p_hi     = s3_lap_r * kh_s;
  assign sum_v    = SW'(p_hi) + SW'(s3_t2_r >>> HB);
  assign term_nxt = first_r ? (sum_v >>> (wes2d_pkg::SHIFT_FIRST - HB))
                            : (sum_v >>> (wes2d_pkg::SHIFT_NORM - HB));

  // --------------------------------------------------------------------------
  // stage 4: time step sum and clipping
  // --------------------------------------------------------------------------
  logic                 s4_int_r, s4_dbl_r;
  logic [CW-1:0]        s4_tr_r, s4_col_r;
  logic signed [VW-1:0] s4_above_r, s4_prev_r;
  logic signed [SW-1:0] s4_term_r;
  logic signed [FW-1:0] full_v;
  logic signed [VW-1:0] val_nxt;
  logic                 sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (s4_en) s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_int_r   <= s3_int_r;
      s4_dbl_r   <= s3_dbl_r;
      s4_tr_r    <= s3_tr_r;
      s4_col_r   <= s3_col_r;
      s4_above_r <= s3_above_r;
      s4_prev_r  <= s3_prev_r;
      s4_term_r  <= term_nxt;
    end
  end

  always_comb begin
    if (first_r) full_v = FW'(s4_above_r) + FW'(s4_term_r);
    else         full_v = (FW'(s4_above_r) <<< 1) - FW'(s4_prev_r) + FW'(s4_term_r);
    // border cells give zero
    priority if (!s4_int_r) begin
      val_nxt = '0;
      sat_nxt = 1'b0;
    end else if (full_v > VMAX_F) begin
      val_nxt = VW'(VMAX_F);
      sat_nxt = 1'b1;
    end else if (full_v < VMIN_F) begin
      val_nxt = VW'(VMIN_F);
      sat_nxt = 1'b1;
    end else begin
      val_nxt = VW'(full_v);
      sat_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // output register; bottom-row cells emit a second zero beat
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] out_val_r;
  logic [CW-1:0]        out_tr_r, out_col_r;
  logic                 out_sat_r;
  logic [PB-1:0]        beat_row, beat_col;
  logic signed [VW-1:0] beat_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      out_ph_r  <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= s4_vld_r;
      out_ph_r  <= 1'b0;
    end else if (out_tready && out_dbl_r && !out_ph_r) begin
      out_ph_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_val_r <= val_nxt;
      out_sat_r <= sat_nxt;
      out_dbl_r <= s4_dbl_r;
      out_tr_r  <= s4_tr_r;
      out_col_r <= s4_col_r;
    end
  end

  assign beat_val   = out_ph_r ? '0 : out_val_r;
  assign beat_row   = out_ph_r ? PB'(out_tr_r + CW'(1)) : PB'(out_tr_r);
  assign beat_col   = PB'(out_col_r);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = ODW'({beat_col, beat_row, beat_val});
  assign out_tuser  = out_ph_r ? 1'b0 : out_sat_r;
  assign out_tlast  = out_ph_r || !out_dbl_r;

endmodule

// ===== tb/wave_equation_stencil_2d_core_test.sv =====
// ----------------------------------------------------------------------------
// wave_equation_stencil_2d_core_test
// Streams grids of cells through the stencil core and checks every result
// beat against a cycle-free predictor of one wave-equation time step. The
// predictor keeps its own line stores and register copy. The stimulus
// covers saturating results, both update rules, clamped grid sizes, frame
// restarts and a grid shrunk mid-frame, with random stalls on both channels.
// ----------------------------------------------------------------------------
module wave_equation_stencil_2d_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS       = 1024;
  localparam int QUIET_LIMIT = 2000;

  // one expected result beat
  typedef struct {
    logic [31:0] value;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        sat;
    logic        last;
  } cell_update_t;

  // predictor of one time step plus the queue of results still owed
  class wave_step_checker;
    logic [wes2d_pkg::COEF_BITS-1:0] coef       = wes2d_pkg::COEF_RST;
    logic                            first_mode = 1'b0;
    logic [wes2d_pkg::GRID_BITS-1:0] grid_reg   = wes2d_pkg::GRID_RST;

    int unsigned  row_idx;
    int unsigned  col_idx;
    longint       cur_above[CELLS];
    longint       cur_two_above[CELLS];
    longint       prev_above[CELLS];
    longint       left_val;
    cell_update_t owed_updates[$];
    int           errors;

    function int unsigned grid_cells();
      int unsigned n;
      n = grid_reg;
      if (n < wes2d_pkg::GRID_MIN) n = wes2d_pkg::GRID_MIN;
      if (n > CELLS) n = CELLS;
      return n;
    endfunction

    function int pending();
      return owed_updates.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t ns: mismatch: %s", $time, msg);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        wes2d_pkg::REG_STEP_COEF:  coef       = val[wes2d_pkg::COEF_BITS-1:0];
        wes2d_pkg::REG_FIRST_STEP: first_mode = val[0];
        wes2d_pkg::REG_GRID_SIZE:  grid_reg   = val[wes2d_pkg::GRID_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void check_reg(logic [1:0] idx, logic [31:0] got);
      logic [31:0] want;
      want = '0;
      case (idx)
        wes2d_pkg::REG_STEP_COEF:  want[wes2d_pkg::COEF_BITS-1:0] = coef;
        wes2d_pkg::REG_FIRST_STEP: want[0]                        = first_mode;
        wes2d_pkg::REG_GRID_SIZE:  want[wes2d_pkg::GRID_BITS-1:0] = grid_reg;
        default: ;
      endcase
      if (got !== want)
        flag($sformatf("register %0d read %h, expected %h", idx, got, want));
    endfunction

    // k*L scaled by 2^-shift, rounded half up
    function longint scaled_term(longint lap, int shift);
      longint prod;
      prod = lap * longint'(coef) + (longint'(1) << (shift - 1));
      return prod >>> shift;
    endfunction

    function void owe(longint v, int unsigned r, int unsigned c, bit sat, bit last);
      cell_update_t u;
      u.value = v[31:0];
      u.row   = r[9:0];
      u.col   = c[9:0];
      u.sat   = sat;
      u.last  = last;
      owed_updates.push_back(u);
    endfunction

    // accepted input cell: advance position, owe the cell above
    function void note_cell(logic [31:0] cur_raw, logic [31:0] prev_raw, logic fs);
      int unsigned n, r, c;
      longint cur, above, lap, v;
      bit sat;
      n   = grid_cells();
      cur = longint'($signed(cur_raw));
      if (fs) begin
        row_idx = 0;
        col_idx = 0;
      end
      if (col_idx >= n) begin
        col_idx = 0;
        row_idx++;
      end
      if (row_idx >= n) row_idx = 0;
      r     = row_idx;
      c     = col_idx;
      above = cur_above[c];

      if (r >= 1) begin
        v   = 0;
        sat = 1'b0;
        // interior target cell; borders stay zero
        if (r - 1 >= 1 && r - 1 <= n - 2 && c >= 1 && c <= n - 2) begin
          lap = cur_two_above[c] + cur + left_val + cur_above[c + 1] - 4 * above;
          if (first_mode)
            v = above + scaled_term(lap, wes2d_pkg::SHIFT_FIRST);
          else
            v = 2 * above - prev_above[c] + scaled_term(lap, wes2d_pkg::SHIFT_NORM);
          if (v > 64'sh7FFF_FFFF) begin
            v   = 64'sh7FFF_FFFF;
            sat = 1'b1;
          end else if (v < -64'sh8000_0000) begin
            v   = -64'sh8000_0000;
            sat = 1'b1;
          end
        end
        owe(v, r - 1, c, sat, r != n - 1);
        // bottom row also emits itself as zero
        if (r == n - 1) owe(0, r, c, 1'b0, 1'b1);
      end

      left_val         = above;
      cur_two_above[c] = above;
      cur_above[c]     = cur;
      prev_above[c]    = longint'($signed(prev_raw));

      col_idx = c + 1;
      if (col_idx >= n) begin
        col_idx = 0;
        row_idx = r + 1;
        if (row_idx >= n) row_idx = 0;
      end
    endfunction

    // accepted result beat against the oldest owed result
    function void check_update(logic [55:0] data, logic sat, logic last);
      cell_update_t u;
      if (owed_updates.size() == 0) begin
        flag($sformatf("unexpected result value=%h row=%0d col=%0d",
                       data[31:0], data[41:32], data[51:42]));
        return;
      end
      u = owed_updates.pop_front();
      if (data[31:0] !== u.value || data[41:32] !== u.row || data[51:42] !== u.col ||
          sat !== u.sat || last !== u.last)
        flag($sformatf({"cell (%0d,%0d) expected value=%h sat=%b last=%b, ",
                        "got (%0d,%0d) value=%h sat=%b last=%b"},
                       u.row, u.col, u.value, u.sat, u.last,
                       data[41:32], data[51:42], data[31:0], sat, last));
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [63:0]                    in_tdata;   // [31:0] cur_value, [63:32] prev_value
  logic [0:0]                     in_tuser;   // [0] frame_start
  logic                           out_tvalid;
  logic                           out_tready;
  logic [55:0]                    out_tdata;  // [31:0] new_value, [41:32] row, [51:42] col
  logic [0:0]                     out_tuser;  // [0] saturated
  logic                           out_tlast;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [wes2d_pkg::CFG_AW-1:0]   paddr;
  logic [wes2d_pkg::CFG_DW-1:0]   pwdata;
  logic [wes2d_pkg::CFG_DW-1:0]   prdata;
  logic                           pready;

  wave_step_checker sb = new;
  bit               idle_on;
  bit               stall_on;
  int               quiet_cycles;

  wave_equation_stencil_2d_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // beat monitor and activity count for the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_cell(in_tdata[31:0], in_tdata[63:32], in_tuser[0]);
      if (out_tvalid && out_tready) sb.check_update(out_tdata, out_tuser[0], out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    int burst;
    burst      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && stall_on && burst == 0 && $urandom_range(0, 5) == 0)
        burst = $urandom_range(1, 9);
      if (burst > 0) begin
        out_tready <= 1'b0;
        burst--;
      end else begin
        out_tready <= rst_n;
      end
    end
  end

  // one input beat; starts and ends at a falling edge
  task automatic send_cell(logic [31:0] cur, logic [31:0] prv, logic fs);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {prv, cur};
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // one APB transfer, ending with psel and penable low
  task automatic cfg_access(logic [1:0] idx, logic [31:0] value, logic wr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr) sb.check_reg(idx, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    cfg_access(idx, value, 1'b1);
    cfg_access(idx, '0, 1'b0);
  endtask

  // drain, then reprogram all registers (junk in the unused upper bits)
  task automatic set_mode(logic [10:0] grid, logic first, logic [23:0] k);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_write(wes2d_pkg::REG_STEP_COEF, {8'($urandom()), k});
    cfg_write(wes2d_pkg::REG_FIRST_STEP, {31'($urandom()), first});
    cfg_write(wes2d_pkg::REG_GRID_SIZE, {21'($urandom()), grid});
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 2))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          default: return 32'h0;
        endcase
      end
      // within +-32.0
      default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    endcase
  endfunction

  // raster frames with random content; noise restarts a frame early
  task automatic run_cells(int count, bit noise, bit first_fs);
    int unsigned n;
    int unsigned pos;
    logic        fs;
    n   = sb.grid_cells();
    pos = 0;
    for (int i = 0; i < count; i++) begin
      fs = (pos == 0);
      if (i == 0) fs = first_fs;
      if (noise && i > 0 && $urandom_range(0, 59) == 0) begin
        fs  = 1'b1;
        pos = 0;
      end
      send_cell(pick_value(), pick_value(), fs);
      pos++;
      if (pos == n * n) pos = 0;
    end
  endtask

  // main sequence
  initial begin
    logic [23:0] k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_on   = 1'b1;
    stall_on  = 1'b1;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values
    cfg_access(wes2d_pkg::REG_STEP_COEF, '0, 1'b0);
    cfg_access(wes2d_pkg::REG_FIRST_STEP, '0, 1'b0);
    cfg_access(wes2d_pkg::REG_GRID_SIZE, '0, 1'b0);

    // 3x3 grid, full coefficient: center saturates high, then low
    set_mode(11'd3, 1'b0, 24'hFF_FFFF);
    for (int p = 0; p < 9; p++)
      send_cell(p == 4 ? 32'h8000_0000 : 32'h7FFF_FFFF, p == 4 ? 32'h8000_0000 : 32'h0,
                p == 0);
    for (int p = 0; p < 9; p++)
      send_cell(p == 4 ? 32'h7FFF_FFFF : 32'h8000_0000, p == 4 ? 32'h7FFF_FFFF : 32'h0,
                p == 0);
    // start rule; previous values must be ignored
    set_mode(11'd3, 1'b1, 24'h80_0000);
    for (int p = 0; p < 9; p++)
      send_cell(32'(p) << 16, 32'h7FFF_FFFF, p == 0);

    // grid size below the minimum clamps to 3
    set_mode(11'd0, 1'b0, 24'($urandom()));
    run_cells(80, 1'b1, 1'b1);
    // zero coefficient, start rule
    set_mode(11'd5, 1'b1, 24'h0);
    run_cells(80, 1'b1, 1'b1);
    set_mode(11'd8, 1'b0, 24'hFF_FFFF);
    run_cells(100, 1'b1, 1'b1);

    // grid shrunk in the middle of a frame
    k = 24'($urandom());
    set_mode(11'd9, 1'b0, k);
    run_cells(40, 1'b0, 1'b1);
    set_mode(11'd6, 1'b0, k);
    run_cells(60, 1'b0, 1'b0);

    // oversize grid clamps to the largest; part of a long row, then shrink
    k = 24'($urandom());
    set_mode(11'd2047, 1'b0, k);
    run_cells(30, 1'b0, 1'b1);
    set_mode(11'd8, 1'b0, k);
    run_cells(50, 1'b0, 1'b0);

    set_mode(11'd12, 1'b1, 24'($urandom()));
    run_cells(120, 1'b1, 1'b1);
    set_mode(11'd1, 1'b0, 24'($urandom()));
    run_cells(60, 1'b1, 1'b1);

    // closing stretch at full rate on both sides
    set_mode(11'd7, 1'b0, 24'($urandom()));
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_cells(100, 1'b1, 1'b1);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
